[rtl/kvlt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kvlt_pkg
// Types, phase codes and character classes for the key/value line tokenizer.
// ----------------------------------------------------------------------------
package kvlt_pkg;

    localparam int PHASE_W = 4;

    localparam logic [PHASE_W-1:0] PH_LINE_START    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_LINE_COMMENT  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_KEY           = 4'd2;
    localparam logic [PHASE_W-1:0] PH_AFTER_KEY     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_AFTER_EQ      = 4'd4;
    localparam logic [PHASE_W-1:0] PH_QUOTED        = 4'd5;
    localparam logic [PHASE_W-1:0] PH_BARE          = 4'd6;
    localparam logic [PHASE_W-1:0] PH_TRAIL         = 4'd7;
    localparam logic [PHASE_W-1:0] PH_TRAIL_COMMENT = 4'd8;
    localparam logic [PHASE_W-1:0] PH_FINISHED      = 4'd9;
    localparam logic [PHASE_W-1:0] PH_ERROR         = 4'd10;

    localparam logic [1:0] TAG_NONE  = 2'd0;
    localparam logic [1:0] TAG_KEY   = 2'd1;
    localparam logic [1:0] TAG_VALUE = 2'd2;

    localparam logic [7:0] CH_END     = 8'd0;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_QUOTE   = 8'd34;
    localparam logic [7:0] CH_HASH    = 8'd35;
    localparam logic [7:0] CH_EQUAL   = 8'd61;
    localparam logic [7:0] CH_PRINT   = 8'd33;

    typedef struct packed {
        logic [7:0] ch;
        logic       restart;
    } kvlt_item_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [1:0]  tag;
        logic        key_start;
        logic        pair_done;
        logic        syntax_error;
        logic        finished;
        logic [15:0] pair_total;
    } kvlt_result_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_next;
        logic [1:0]         tag;
        logic               key_start;
        logic               pair_done;
    } kvlt_step_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c != CH_END) && (c < CH_PRINT) && (c != CH_NEWLINE);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'd97) && (c <= 8'd122)) || ((c >= 8'd65) && (c <= 8'd90));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

endpackage
`default_nettype wire

[rtl/kvlt_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kvlt_step
// Phase transition and byte classification for one text byte.
// ----------------------------------------------------------------------------
module kvlt_step
    import kvlt_pkg::*;
(
    input  wire logic [PHASE_W-1:0] phase,
    input  wire logic [7:0]         ch,
    output kvlt_step_t              step
);

    logic blank;
    logic printable;

    assign blank     = is_blank(ch);
    assign printable = (ch >= CH_PRINT);

    always_comb
    begin
        step            = '0;
        step.phase_next = phase;
        unique case (phase)
            PH_LINE_START:
            begin
                if (blank || ch == CH_NEWLINE)
                begin
                end
                else if (ch == CH_END)
                    step.phase_next = PH_FINISHED;
                else if (ch == CH_HASH)
                    step.phase_next = PH_LINE_COMMENT;
                else if (is_letter(ch))
                begin
                    step.phase_next = PH_KEY;
                    step.tag        = TAG_KEY;
                    step.key_start  = 1'b1;
                end
                else
                    step.phase_next = PH_ERROR;
            end
            PH_LINE_COMMENT:
            begin
                if (ch == CH_NEWLINE)
                    step.phase_next = PH_LINE_START;
                else if (ch == CH_END)
                    step.phase_next = PH_FINISHED;
            end
            PH_KEY, PH_AFTER_KEY:
            begin
                // a non-alphanumeric byte ends the key and is judged here
                if (phase == PH_KEY && (is_letter(ch) || is_digit(ch)))
                    step.tag = TAG_KEY;
                else if (blank)
                    step.phase_next = PH_AFTER_KEY;
                else if (ch == CH_EQUAL)
                    step.phase_next = PH_AFTER_EQ;
                else
                    step.phase_next = PH_ERROR;
            end
            PH_AFTER_EQ:
            begin
                if (blank)
                begin
                end
                else if (ch == CH_QUOTE)
                    step.phase_next = PH_QUOTED;
                else if (printable)
                begin
                    step.phase_next = PH_BARE;
                    step.tag        = TAG_VALUE;
                end
                else
                    step.phase_next = PH_ERROR;
            end
            PH_QUOTED:
            begin
                if (ch == CH_QUOTE)
                    step.phase_next = PH_TRAIL;
                else if (ch == CH_NEWLINE || ch == CH_END)
                    step.phase_next = PH_ERROR;
                else
                    step.tag = TAG_VALUE;
            end
            PH_BARE, PH_TRAIL:
            begin
                // the first byte below 33 ends a bare value and is judged here
                if (phase == PH_BARE && printable)
                    step.tag = TAG_VALUE;
                else if (blank)
                    step.phase_next = PH_TRAIL;
                else if (ch == CH_HASH)
                    step.phase_next = PH_TRAIL_COMMENT;
                else if (ch == CH_NEWLINE)
                begin
                    step.phase_next = PH_LINE_START;
                    step.pair_done  = 1'b1;
                end
                else if (ch == CH_END)
                begin
                    step.phase_next = PH_FINISHED;
                    step.pair_done  = 1'b1;
                end
                else
                    step.phase_next = PH_ERROR;
            end
            PH_TRAIL_COMMENT:
            begin
                if (ch == CH_NEWLINE)
                begin
                    step.phase_next = PH_LINE_START;
                    step.pair_done  = 1'b1;
                end
                else if (ch == CH_END)
                begin
                    step.phase_next = PH_FINISHED;
                    step.pair_done  = 1'b1;
                end
            end
            PH_FINISHED:
            begin
            end
            default:
                step.phase_next = PH_ERROR;
        endcase
    end

endmodule
`default_nettype wire

[rtl/key_value_line_tokenizer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// key_value_line_tokenizer_top
// Byte-serial tokenizer for "key = value" configuration text.
// ----------------------------------------------------------------------------
//  Channel | Handshake                    | Payload
//  --------+------------------------------+----------------------------------
//  item    | item_valid / item_ready      | kvlt_item_t   (ch, restart)
//  result  | result_valid / result_ready  | kvlt_result_t (one per item)
//
//  One byte per cycle sustained unless the result stalls; a byte passes the
//  input register, then phase logic into the result register. The phase
//  and pair counter update as a byte moves into the result register, so
//  bytes follow back to back. Reset puts the phase at line start and clears
//  the counter and both valid flags. A stalled result holds both stages;
//  item_ready drops only when the input register is full and cannot advance.
// ----------------------------------------------------------------------------
module key_value_line_tokenizer_top
    import kvlt_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   item_valid,
    output logic        item_ready,
    input  wire kvlt_item_t item,
    output logic        result_valid,
    input  wire logic   result_ready,
    output kvlt_result_t result
);

    logic                   s1_valid_reg;
    kvlt_item_t             s1_item_reg;
    logic                   out_valid_reg;
    kvlt_result_t           out_reg;
    kvlt_result_t           out_next;
    logic [PHASE_W-1:0]     phase_reg;
    logic [PHASE_W-1:0]     phase_cur;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_cur;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   s1_adv;
    kvlt_step_t             step;

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || s1_adv;

    // restart clears phase and count before the byte is handled
    assign phase_cur = s1_item_reg.restart ? PH_LINE_START : phase_reg;
    assign count_cur = s1_item_reg.restart ? '0 : count_reg;

    kvlt_step u_step (
        .phase (phase_cur),
        .ch    (s1_item_reg.ch),
        .step  (step)
    );

    always_comb
    begin
        count_next = count_cur;
        if (step.pair_done && count_cur != '1)
            count_next = count_cur + 1'b1;
    end

    always_comb
    begin
        out_next.byte_out     = s1_item_reg.ch;
        out_next.tag          = step.tag;
        out_next.key_start    = step.key_start;
        out_next.pair_done    = step.pair_done;
        out_next.syntax_error = (step.phase_next == PH_ERROR);
        out_next.finished     = (step.phase_next == PH_FINISHED);
        out_next.pair_total   = 16'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_LINE_START;
            count_reg     <= '0;
        end
        else
        begin
            if (item_ready)
                s1_valid_reg <= item_valid;
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= step.phase_next;
                count_reg     <= count_next;
            end
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers: load on transaction / advance
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            s1_item_reg <= item;
        if (s1_adv)
            out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_fin_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.finished && result.syntax_error))
        else $error("finished and syntax_error both set");

    a_kstart_key: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.key_start) |-> (result.tag == TAG_KEY))
        else $error("key_start on a byte not tagged as key");

    a_done_untagged: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.pair_done) |-> (result.tag == TAG_NONE))
        else $error("pair_done on a tagged byte");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_item_reg.restart && step.pair_done && count_reg != '1)
        |=> (count_reg == COUNT_WIDTH'($past(count_reg) + 1'b1)))
        else $error("pair counter did not advance on a completed pair");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_adv) |=> (phase_reg == $past(phase_reg) && count_reg == $past(count_reg)))
        else $error("state changed without an advancing byte");

endmodule
`default_nettype wire
